[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a rising clock, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
// Shared constants and types of the sorted priority queue.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OCC_W    = 5;
   localparam int STAT_W   = 2;

   localparam logic       MODE_INSERT = 1'b0;
   localparam logic       MODE_REMOVE = 1'b1;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

   // Broadcast to every cell.
   typedef struct packed {
      logic [1:0]              op;
      logic signed [VAL_W-1:0] key;
   } cell_ctl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic                    valid;
      logic                    take;
      logic signed [VAL_W-1:0] value;
   } cell_state_type;

endpackage

[rtl/core/sorted_array_priority_queue.sv]
// An accepted item's result is written into the output register in the cycle after it is accepted.
// Throughput: one item per cycle; every cell compares and shifts in that same cycle.
// An item is taken while the output register is empty or is being drained.
// Reset (synchronous, active high) empties the chain and the count at once;
// stored values are not cleared and are never shown before they are written.
module sorted_array_priority_queue
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] job_value
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [36:32] occupancy, [39:37] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

`include "assert_macros.svh"

   cell_ctl_type            ctl;
   cell_state_type          cells [CAPACITY];
   logic [CAPACITY-1:0]     valid_vec;
   logic                    accept;
   logic                    mode;
   logic                    full;
   logic                    empty;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W+OCC_W-1:0]  count_wide;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [VAL_W-1:0] removed_ff;
   logic signed [VAL_W-1:0] removed_in;
   logic [STAT_W-1:0]       status_ff;
   logic [STAT_W-1:0]       status_in;
   logic [OCC_W-1:0]        occ_ff;
   logic [OCC_W-1:0]        occ_in;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign mode       = req_tuser[0];
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);

   always_comb begin
      ctl.op     = OP_HOLD;
      ctl.key    = req_tdata;
      count_in   = count_ff;
      status_in  = STAT_OK;
      removed_in = '0;
      if (mode == MODE_INSERT) begin
         if (full) begin
            status_in = STAT_OVERFLOW;
         end else begin
            ctl.op   = accept ? OP_INSERT : OP_HOLD;
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = STAT_UNDERFLOW;
         end else begin
            ctl.op     = accept ? OP_REMOVE : OP_HOLD;
            count_in   = count_ff - CNT_W'(1);
            removed_in = cells[0].value;
         end
      end
   end

   assign count_wide   = {{OCC_W{1'b0}}, count_in};
   assign occ_in       = count_wide[OCC_W-1:0];
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_tready);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         cell_state_type left_s;
         cell_state_type right_s;

         if (g == 0) begin : g_head
            // The head takes the key itself and counts as filled after an insert.
            assign left_s.valid = 1'b1;
            assign left_s.take  = 1'b0;
            assign left_s.value = '0;
         end else begin : g_mid
            assign left_s = cells[g-1];
         end

         if (g == CAPACITY - 1) begin : g_tail
            assign right_s.valid = 1'b0;
            assign right_s.take  = 1'b0;
            assign right_s.value = '0;
         end else begin : g_body
            assign right_s = cells[g+1];
         end

         spq_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .left  (left_s),
            .right (right_s),
            .state (cells[g])
         );

         assign valid_vec[g] = cells[g].valid;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the result until it is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
         occ_ff     <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, occ_ff, removed_ff};
   assign rsp_tuser  = status_ff;

   `ASSERT_CLK(a_count_matches_cells, clock, reset,
      $countones(valid_vec) == 32'(count_ff), "count disagrees with filled cells")
   `ASSERT_CLK(a_cells_packed, clock, reset,
      ((valid_vec + CAPACITY'(1)) & valid_vec) == '0, "filled cells are not contiguous")
   `ASSERT_CLK(a_remove_returns_head, clock, reset,
      (accept && mode == MODE_REMOVE && !empty) |=>
         (rsp_tvalid && removed_ff == $past(cells[0].value)),
      "remove did not return the head")
   `ASSERT_ALWAYS(a_no_overflow_on_room, clock,
      (!reset && accept && mode == MODE_INSERT && !full) |=> (status_ff == STAT_OK),
      "insert with room flagged an error")

endmodule

[rtl/core/spq_cell.sv]
// One entry of the sorted chain: compare against the key and shift with neighbors.
module spq_cell
   import spq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctl_type   ctl,
   input  cell_state_type left,
   input  cell_state_type right,
   output cell_state_type state
);

   logic                    valid_ff;
   logic                    valid_in;
   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;
   logic                    take;

   // The key goes at or below this cell when the cell is empty or holds a larger value.
   assign take = ~valid_ff | (ctl.key < value_ff);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (take) begin
               value_in = left.take ? left.value : ctl.key;
               valid_in = valid_ff | left.valid;
            end
         end
         OP_REMOVE: begin
            value_in = right.value;
            valid_in = right.valid;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign state.valid = valid_ff;
   assign state.take  = take;
   assign state.value = value_ff;

endmodule

[tb/priority_queue_checker.sv]
// Checker for the sorted priority queue: predicts each item's result and compares it.
`timescale 1ns / 100ps

module priority_queue_checker
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] job_value
   input  logic [0:0]  req_tuser,   // [0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] removed_value, [36:32] occupancy, [39:37] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic signed [VAL_W-1:0] removed;
      logic [STAT_W-1:0]       status;
      logic [OCC_W-1:0]        occupancy;
   } job_result_type;

   logic signed [VAL_W-1:0] job_store [CAPACITY];
   int                      job_count;
   job_result_type          awaited_results [$];

   // Apply one item to the sorted store and return the result it should produce.
   function automatic job_result_type apply_job(input logic mode,
                                                input logic signed [VAL_W-1:0] value);
      job_result_type r;
      int             slot;
      r.removed = '0;
      r.status  = STAT_OK;
      if (mode == MODE_INSERT) begin
         if (job_count >= CAPACITY) begin
            r.status = STAT_OVERFLOW;
         end else begin
            // shift larger values up; equal values stay ahead of the new one
            slot = job_count;
            while (slot > 0 && value < job_store[slot-1]) begin
               job_store[slot] = job_store[slot-1];
               slot--;
            end
            job_store[slot] = value;
            job_count++;
         end
      end else begin
         if (job_count == 0) begin
            r.status = STAT_UNDERFLOW;
         end else begin
            r.removed = job_store[0];
            for (int i = 1; i < job_count; i++) job_store[i-1] = job_store[i];
            job_count--;
         end
      end
      r.occupancy = job_count[OCC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      job_result_type seen;
      job_result_type want;
      if (reset) begin
         job_count     = 0;
         error_count   = 0;
         pending_count = 0;
         awaited_results.delete();
      end else begin
         // results leave in the cycle after their item at the earliest, so drain first
         if (rsp_tvalid && rsp_tready) begin
            seen.removed   = rsp_tdata[31:0];
            seen.occupancy = rsp_tdata[36:32];
            seen.status    = rsp_tuser;
            if (rsp_tdata[39:37] != 3'b000) begin
               $error("padding: expected 0, actual %0d", rsp_tdata[39:37]);
               error_count++;
            end
            if (awaited_results.size() == 0) begin
               $error("result with no item waiting: removed_value %0d status %0d occupancy %0d",
                      seen.removed, seen.status, seen.occupancy);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (seen.removed !== want.removed) begin
                  $error("removed_value: expected %0d, actual %0d", want.removed, seen.removed);
                  error_count++;
               end
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, seen.status);
                  error_count++;
               end
               if (seen.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d", want.occupancy, seen.occupancy);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(apply_job(req_tuser[0], req_tdata));
         pending_count = awaited_results.size();
      end
   end

endmodule

[tb/sorted_array_priority_queue_test.sv]
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sorted_array_priority_queue_test;
   import spq_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PULSE} ready_style_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] job_value
   logic [0:0]  req_tuser;    // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;    // [31:0] removed_value, [36:32] occupancy, [39:37] zero
   logic [1:0]  rsp_tuser;    // [1:0] status

   int              error_count;
   int              pending_count;
   int              cycle_count = 0;
   int              burst_left;
   int              ready_span  = 0;
   ready_style_type ready_style = READY_ALWAYS;

   sorted_array_priority_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   priority_queue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: switch between stall patterns, each held for a random span.
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         ready_span  = $urandom_range(8, 60);
      end
      ready_span--;
      case (ready_style)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= ready_span[1];
      endcase
   end

   // Offer one item and hold it until the queue takes it; returns at the accepting edge.
   task automatic send_item(input logic mode, input logic signed [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= mode;
      // inputs and state only move at the rising edge, so ready is settled here
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      burst_left--;
   endtask

   function automatic logic signed [31:0] random_job_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       v = 32'sh7FFF_FFFF;
               1:       v = 32'sh8000_0000;
               2:       v = 32'sd0;
               default: v = -32'sd1;
            endcase
         end
         1, 2, 3, 4: begin
            // narrow range: plenty of equal values
            v = $urandom_range(0, 15);
            v = v - 32'sd8;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin
      int sent;
      int run_len;
      int insert_odds;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      burst_left  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // remove from an empty queue, with junk in the data field
      send_item(MODE_REMOVE, 32'sh1234_5678);
      send_item(MODE_INSERT, 32'sd0);
      send_item(MODE_INSERT, 32'sh7FFF_FFFF);
      send_item(MODE_INSERT, 32'sh8000_0000);
      send_item(MODE_INSERT, -32'sd1);
      send_item(MODE_INSERT, 32'sd1);
      send_item(MODE_INSERT, 32'sd5);
      send_item(MODE_INSERT, 32'sd5);
      send_item(MODE_INSERT, -32'sd5);
      send_item(MODE_INSERT, 32'sh8000_0001);
      send_item(MODE_INSERT, 32'sh7FFF_FFFE);
      send_item(MODE_INSERT, 32'sd3);
      send_item(MODE_INSERT, 32'sd3);
      send_item(MODE_INSERT, -32'sd1);
      send_item(MODE_INSERT, 32'sd100);
      send_item(MODE_INSERT, -32'sd100);
      send_item(MODE_INSERT, 32'sd0);
      // queue is full now: both inserts must bounce
      send_item(MODE_INSERT, 32'sh8000_0000);
      send_item(MODE_INSERT, 32'sh7FFF_FFFF);
      repeat (4) send_item(MODE_REMOVE, 32'shFFFF_FFFF);

      // random phases that lean toward filling, draining or neither
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       insert_odds = 8;
            1:       insert_odds = 2;
            default: insert_odds = 5;
         endcase
         run_len = $urandom_range(10, 50);
         repeat (run_len) begin
            if ($urandom_range(0, 9) < insert_odds)
               send_item(MODE_INSERT, random_job_value());
            else
               send_item(MODE_REMOVE, $urandom);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      do @(negedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_array_priority_queue.sv
tb/priority_queue_checker.sv
tb/sorted_array_priority_queue_test.sv
